[sv/vcsl_pkg.sv]
// types, register codes and helper functions of the velocity command slew limiter
package vcsl_pkg;

  localparam int unsigned VelW   = 16;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned LimW   = 15;
  localparam int unsigned MaskW  = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TimeW-1:0] TimeoutReset = 16'd6554;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INVERT_MASK   = 3'd0,
    CFG_LIN_RISE      = 3'd1,
    CFG_LIN_FALL      = 3'd2,
    CFG_ANG_RISE      = 3'd3,
    CFG_ANG_FALL      = 3'd4,
    CFG_LIN_MAX       = 3'd5,
    CFG_ANG_MAX       = 3'd6,
    CFG_CMD_TIMEOUT   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [LimW-1:0] rise;
    logic [LimW-1:0] fall;
  } slew_lim_t;

  // optional saturating negate, then magnitude clamp (zero max disables)
  function automatic logic signed [VelW-1:0] shape_cmd(
    input logic signed [VelW-1:0] v,
    input logic                   neg,
    input logic [LimW-1:0]        maxv
  );
    logic signed [VelW-1:0] r;
    logic signed [VelW-1:0] m;
    r = v;
    m = $signed({1'b0, maxv});
    if (neg) begin
      if (v == {1'b1, {(VelW-1){1'b0}}}) begin
        r = {1'b0, {(VelW-1){1'b1}}};
      end else begin
        r = -v;
      end
    end
    if (maxv != '0) begin
      if (r > m) begin
        r = m;
      end else if (r < -m) begin
        r = -m;
      end
    end
    return r;
  endfunction

  // saturate a 17-bit signed value to 16 bits
  function automatic logic signed [VelW-1:0] sat_vel(input logic signed [VelW:0] v);
    logic signed [VelW-1:0] r;
    if (v[VelW] != v[VelW-1]) begin
      r = v[VelW] ? {1'b1, {(VelW-1){1'b0}}} : {1'b0, {(VelW-1){1'b1}}};
    end else begin
      r = v[VelW-1:0];
    end
    return r;
  endfunction

endpackage

[sv/vcsl_if.sv]
// handshake channel interfaces: drive items, tick results, register writes
interface vcsl_item_if import vcsl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [VelW-1:0]  linear_cmd;
  logic signed [VelW-1:0]  angular_cmd;
  logic [TimeW-1:0]        step_time;

  modport source (output valid, cmd, linear_cmd, angular_cmd, step_time, input ready);
  modport sink   (input valid, cmd, linear_cmd, angular_cmd, step_time, output ready);
endinterface

interface vcsl_result_if import vcsl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VelW-1:0]  linear_vel;
  logic signed [VelW-1:0]  angular_vel;
  logic signed [VelW-1:0]  distance_step;
  logic signed [VelW-1:0]  heading_step;
  logic                    timed_out;

  modport source (output valid, linear_vel, angular_vel, distance_step, heading_step,
                  timed_out, input ready);
  modport sink   (input valid, linear_vel, angular_vel, distance_step, heading_step,
                  timed_out, output ready);
endinterface

interface vcsl_cfg_if import vcsl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CfgIdxW-1:0]    index;
  logic [CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/vcsl_ramp.sv]
// one slew step of a velocity toward its target, separate rise and fall limits
module vcsl_ramp import vcsl_pkg::*; (
  input  logic signed [VelW-1:0] cur_i,
  input  logic signed [VelW-1:0] tgt_i,
  input  slew_lim_t              lim_i,
  output logic signed [VelW-1:0] nxt_o
);

  logic signed [VelW:0] cur_x;
  logic signed [VelW:0] tgt_x;
  logic signed [VelW:0] up_gap;
  logic signed [VelW:0] down_gap;
  logic signed [VelW:0] rise_x;
  logic signed [VelW:0] fall_x;

  assign cur_x    = {cur_i[VelW-1], cur_i};
  assign tgt_x    = {tgt_i[VelW-1], tgt_i};
  assign up_gap   = tgt_x - cur_x;
  assign down_gap = cur_x - tgt_x;
  assign rise_x   = $signed({2'b00, lim_i.rise});
  assign fall_x   = $signed({2'b00, lim_i.fall});

  always_comb begin
    nxt_o = cur_i;
    if (cur_i < tgt_i) begin
      if (lim_i.rise == '0 || up_gap < rise_x) begin
        nxt_o = tgt_i;
      end else begin
        // no overflow: target lies at least one full step above
        nxt_o = cur_i + $signed({1'b0, lim_i.rise});
      end
    end else if (cur_i > tgt_i) begin
      if (lim_i.fall == '0 || down_gap < fall_x) begin
        nxt_o = tgt_i;
      end else begin
        nxt_o = cur_i - $signed({1'b0, lim_i.fall});
      end
    end
  end

endmodule

[sv/velocity_command_slew_limiter_unit.sv]
// velocity command slew limiter: command shaping, timeout, ramp and step integration
// Usage:
//   in_i   carries drive commands (cmd = 0) and time ticks (cmd = 1). A command
//          sets the shaped targets and clears the command age; it gives no
//          result. A tick ages the command, zeroes the targets on timeout,
//          ramps both velocities and gives exactly one result on res_o.
//   res_o  carries the ramped velocities, distance and heading steps and the
//          timeout flag.
//   cfg_i  writes the eight registers by index; always ready. Writes must be made
//          only while idle; the block itself does not enforce this.
// Pipeline: an accepted tick goes into a middle register and then into the result
//   register, which drives res_o. The ramp and state update sit between the input
//   and the middle register, the two products between that and the result register,
//   so one item is taken every cycle until a stall on res_o fills the middle stage.
// Reset clears the velocities, targets and age, loads the register defaults
// and empties both stages. When res_o stalls, the result holds, the middle
// stage fills, and then in_i.ready drops until the result is taken.
module velocity_command_slew_limiter_unit import vcsl_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  vcsl_item_if.sink    in_i,
  vcsl_result_if.source res_o,
  vcsl_cfg_if.sink     cfg_i
);

  // configuration
  logic [MaskW-1:0]  inv_mask_q;
  slew_lim_t         lin_lim_q;
  slew_lim_t         ang_lim_q;
  logic [LimW-1:0]   lin_max_q;
  logic [LimW-1:0]   ang_max_q;
  logic [TimeW-1:0]  timeout_q;

  // state
  logic signed [VelW-1:0] cur_lin_q, cur_ang_q;
  logic signed [VelW-1:0] tgt_lin_q, tgt_ang_q;
  logic [TimeW-1:0]       age_q;

  // middle stage
  logic                   mid_valid_q;
  logic signed [VelW-1:0] mid_prev_q, mid_lin_q, mid_ang_q;
  logic [TimeW-1:0]       mid_dt_q;
  logic                   mid_tout_q;

  // result register
  logic                   out_valid_q;
  logic signed [VelW-1:0] out_lin_q, out_ang_q, out_dist_q, out_head_q;
  logic                   out_tout_q;

  logic in_acc, out_free, mid_adv;
  logic [TimeW:0]         age_sum;
  logic [TimeW-1:0]       age_new;
  logic                   tout;
  logic signed [VelW-1:0] tgt_lin_eff, tgt_ang_eff;
  logic signed [VelW-1:0] lin_nxt, ang_nxt;
  logic signed [VelW-1:0] lin_shaped, ang_shaped;

  logic signed [VelW:0]     vel_sum;
  logic signed [2*VelW+1:0] dist_prod;
  logic signed [2*VelW:0]   head_prod;
  logic signed [2*VelW+1:0] dist_rnd;
  logic signed [2*VelW:0]   head_rnd;

  assign out_free = !out_valid_q || res_o.ready;
  assign mid_adv  = mid_valid_q && out_free;
  assign in_i.ready = !mid_valid_q || out_free;
  assign in_acc   = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // tick path: age, timeout, ramp
  assign age_sum = {1'b0, age_q} + {1'b0, in_i.step_time};
  assign age_new = age_sum[TimeW] ? '1 : age_sum[TimeW-1:0];
  assign tout    = age_new > timeout_q;
  assign tgt_lin_eff = tout ? '0 : tgt_lin_q;
  assign tgt_ang_eff = tout ? '0 : tgt_ang_q;

  vcsl_ramp u_ramp_lin (
    .cur_i (cur_lin_q),
    .tgt_i (tgt_lin_eff),
    .lim_i (lin_lim_q),
    .nxt_o (lin_nxt)
  );

  vcsl_ramp u_ramp_ang (
    .cur_i (cur_ang_q),
    .tgt_i (tgt_ang_eff),
    .lim_i (ang_lim_q),
    .nxt_o (ang_nxt)
  );

  // command path
  assign lin_shaped = shape_cmd(in_i.linear_cmd, inv_mask_q[0], lin_max_q);
  assign ang_shaped = shape_cmd(in_i.angular_cmd, inv_mask_q[1], ang_max_q);

  // trapezoid and heading products, rounded half up by floor after bias
  assign vel_sum   = {mid_prev_q[VelW-1], mid_prev_q} + {mid_lin_q[VelW-1], mid_lin_q};
  assign dist_prod = vel_sum * $signed({1'b0, mid_dt_q});
  assign head_prod = mid_ang_q * $signed({1'b0, mid_dt_q});
  assign dist_rnd  = dist_prod + $signed({{(VelW+1){1'b0}}, 1'b1, {VelW{1'b0}}});
  assign head_rnd  = head_prod + $signed({{(VelW+1){1'b0}}, 1'b1, {(VelW-1){1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_mask_q <= '0;
      lin_lim_q  <= '0;
      ang_lim_q  <= '0;
      lin_max_q  <= '0;
      ang_max_q  <= '0;
      timeout_q  <= TimeoutReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_INVERT_MASK: inv_mask_q     <= cfg_i.data[MaskW-1:0];
        CFG_LIN_RISE:    lin_lim_q.rise <= cfg_i.data[LimW-1:0];
        CFG_LIN_FALL:    lin_lim_q.fall <= cfg_i.data[LimW-1:0];
        CFG_ANG_RISE:    ang_lim_q.rise <= cfg_i.data[LimW-1:0];
        CFG_ANG_FALL:    ang_lim_q.fall <= cfg_i.data[LimW-1:0];
        CFG_LIN_MAX:     lin_max_q      <= cfg_i.data[LimW-1:0];
        CFG_ANG_MAX:     ang_max_q      <= cfg_i.data[LimW-1:0];
        CFG_CMD_TIMEOUT: timeout_q      <= cfg_i.data[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_lin_q   <= '0;
      cur_ang_q   <= '0;
      tgt_lin_q   <= '0;
      tgt_ang_q   <= '0;
      age_q       <= '0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc && !in_i.cmd) begin
        tgt_lin_q <= lin_shaped;
        tgt_ang_q <= ang_shaped;
        age_q     <= '0;
      end else if (in_acc) begin
        tgt_lin_q <= tgt_lin_eff;
        tgt_ang_q <= tgt_ang_eff;
        age_q     <= age_new;
        cur_lin_q <= lin_nxt;
        cur_ang_q <= ang_nxt;
      end
      if (in_i.ready) begin
        mid_valid_q <= in_acc && in_i.cmd;
      end
      if (out_free) begin
        out_valid_q <= mid_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.cmd) begin
      mid_prev_q <= cur_lin_q;
      mid_lin_q  <= lin_nxt;
      mid_ang_q  <= ang_nxt;
      mid_dt_q   <= in_i.step_time;
      mid_tout_q <= tout;
    end
    if (mid_adv) begin
      out_lin_q  <= mid_lin_q;
      out_ang_q  <= mid_ang_q;
      out_dist_q <= sat_vel(dist_rnd[2*VelW+1:VelW+1]);
      out_head_q <= sat_vel(head_rnd[2*VelW:VelW]);
      out_tout_q <= mid_tout_q;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.linear_vel    = out_lin_q;
  assign res_o.angular_vel   = out_ang_q;
  assign res_o.distance_step = out_dist_q;
  assign res_o.heading_step  = out_head_q;
  assign res_o.timed_out     = out_tout_q;

endmodule

[sv/vcsl_checker.sv]
// port-level checks of the slew limiter, bound to the top level
module vcsl_checker import vcsl_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_cmd,
  input logic                   res_valid,
  input logic                   res_ready,
  input logic signed [VelW-1:0] res_linear_vel,
  input logic                   res_timed_out
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its linear velocity and timeout flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> $stable(res_linear_vel) && $stable(res_timed_out))
    else $error("result payload changed while stalled");

  // a fresh result comes only from a tick transaction that passed through the middle register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid) |-> $past(in_valid && in_ready && in_cmd, 2))
    else $error("result without a tick");

  // input backpressure only while the result side is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> res_valid && !res_ready)
    else $error("input stalled with free output");

endmodule

bind velocity_command_slew_limiter_unit vcsl_checker u_vcsl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_i.valid),
  .in_ready       (in_i.ready),
  .in_cmd         (in_i.cmd),
  .res_valid      (res_o.valid),
  .res_ready      (res_o.ready),
  .res_linear_vel (res_o.linear_vel),
  .res_timed_out  (res_o.timed_out)
);
